// ===== rtl/dar_pkg.sv =====
// Shared types and constants for the distance attenuation low-pass block.
`timescale 1ns / 1ps
package dar_pkg;

	localparam int POS_W   = 16;
	localparam int GAIN_W  = 17;
	localparam int COEF_W  = 16;
	localparam int BLEN_W  = 13;
	localparam int CFG_W   = 17;
	localparam int IDX_W   = 3;
	localparam int STEP_W  = 18;
	localparam int DIST_W  = 17;
	localparam int RAD_W   = 32;
	localparam int ROOT_W  = 16;

	localparam logic [GAIN_W-1:0] UNITY_Q16 = 17'd65536;
	localparam logic [DIST_W-1:0] ONE_Q12   = 17'd4096;
	localparam logic [COEF_W-1:0] COEF_MAX  = 16'hFFFF;

	// Configuration register indexes.
	localparam logic [IDX_W-1:0] CFG_POS_X     = 3'd0;
	localparam logic [IDX_W-1:0] CFG_POS_Y     = 3'd1;
	localparam logic [IDX_W-1:0] CFG_POS_Z     = 3'd2;
	localparam logic [IDX_W-1:0] CFG_GAIN_MAX  = 3'd3;
	localparam logic [IDX_W-1:0] CFG_COEF_MAX  = 3'd4;
	localparam logic [IDX_W-1:0] CFG_BLOCK_LEN = 3'd5;

	// Handshake between the sequencer and an iterative unit.
	typedef struct packed {
		logic start;
	} iter_ctl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} iter_sts_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_MX,
		ST_MY,
		ST_MZ,
		ST_ROOT_GO,
		ST_ROOT_WAIT,
		ST_RATIO,
		ST_MUL_G,
		ST_MUL_C,
		ST_DIVG_GO,
		ST_DIVG_WAIT,
		ST_DIVC_GO,
		ST_DIVC_WAIT,
		ST_UPD,
		ST_F1,
		ST_F1W,
		ST_F2,
		ST_F2W,
		ST_G,
		ST_OUT
	} dar_state_t;

endpackage

// ===== rtl/distance_attenuation_ramped_lowpass_core.sv =====
// Top level: distance attenuation with a ramped two-pole low-pass.
//
// Input items arrive on in_valid / in_stall with sample_in; results leave on
// out_valid / out_stall with sample_out and block_end. An item moves on a
// rising edge where valid is high and stall is low. The user must write
// configuration through cfg_we / cfg_index / cfg_data only while idle; the block does not enforce it.
//
// Each item is handled by a small sequencer around one shared multiplier.
// An ordinary sample runs a ramp update, three multiplies of one issue and
// one use state each, and the output write; a bypassed sample skips the
// update and the multiplies. No new item is taken before the current one
// is written to the output register. The first sample of a block also runs
// the distance and target computation: three multiplies, an iterative square
// root, two more multiplies and two iterative divisions.
// in_stall is high while an item is in work.
// The output register holds a result until it is taken; while out_stall is
// high the next item may be accepted and worked up to its final write.
// Reset clears the ramp state to unity gain and zero coefficient, empties
// the filter stages and starts a new block; no clearing pass is needed.
`timescale 1ns / 1ps
module distance_attenuation_ramped_lowpass_core #(
	parameter int MAX_BLOCK   = 4096,
	parameter int SAMPLE_BITS = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [dar_pkg::IDX_W-1:0]       cfg_index,
	input  logic [dar_pkg::CFG_W-1:0]       cfg_data,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic signed [SAMPLE_BITS-1:0]   sample_in,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic signed [SAMPLE_BITS-1:0]   sample_out,
	output logic                            block_end
);
	import dar_pkg::*;

	localparam int LW  = ($clog2(MAX_BLOCK + 1) > BLEN_W) ? $clog2(MAX_BLOCK + 1) : BLEN_W;
	localparam int SW  = SAMPLE_BITS + 8;
	localparam int AW  = (SW + 1 > STEP_W) ? SW + 1 : STEP_W;
	localparam int BW  = STEP_W;
	localparam int PW  = AW + BW;
	localparam int OW  = PW - 24;
	localparam logic [LW-1:0] MAX_LEN = LW'(MAX_BLOCK);

	// Configuration registers.
	logic signed [POS_W-1:0] pos_x_q, pos_y_q, pos_z_q;
	logic [GAIN_W-1:0]       gain_max_q;
	logic [COEF_W-1:0]       coef_max_q;
	logic [BLEN_W-1:0]       blen_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_x_q    <= '0;
			pos_y_q    <= '0;
			pos_z_q    <= '0;
			gain_max_q <= UNITY_Q16;
			coef_max_q <= '0;
			blen_q     <= 13'd256;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_POS_X:     pos_x_q    <= cfg_data[POS_W-1:0];
				CFG_POS_Y:     pos_y_q    <= cfg_data[POS_W-1:0];
				CFG_POS_Z:     pos_z_q    <= cfg_data[POS_W-1:0];
				CFG_GAIN_MAX:  gain_max_q <= cfg_data[GAIN_W-1:0];
				CFG_COEF_MAX:  coef_max_q <= cfg_data[COEF_W-1:0];
				CFG_BLOCK_LEN: blen_q     <= cfg_data[BLEN_W-1:0];
				default: ;
			endcase
		end
	end

	// Effective block length, clamped to 1..MAX_BLOCK.
	logic [LW-1:0] blen_ext, eff_len;
	assign blen_ext = LW'(blen_q);
	always_comb begin
		eff_len = blen_ext;
		if (blen_ext == '0)
			eff_len = LW'(1);
		else if (blen_ext > MAX_LEN)
			eff_len = MAX_LEN;
	end

	// State registers.
	dar_state_t state_q, state_d;
	logic signed [SAMPLE_BITS-1:0] sample_q;
	logic [GAIN_W-1:0]             cur_gain_q;
	logic [COEF_W-1:0]             cur_coef_q;
	logic signed [STEP_W-1:0]      gain_step_q, coef_step_q;
	logic signed [SW-1:0]          stage_one_q, stage_two_q;
	logic [LW-1:0]                 idx_q;
	logic                          bypass_q;
	logic [RAD_W-1:0]              acc_q;
	logic [GAIN_W-1:0]             ratio_q;
	logic [GAIN_W-1:0]             tgain_q;
	logic [COEF_W-1:0]             tcoef_q;
	logic                          out_valid_q, block_end_q;
	logic signed [SAMPLE_BITS-1:0] sample_out_q;

	// Shared units.
	logic                 mul_en;
	logic signed [AW-1:0] mul_a;
	logic signed [BW-1:0] mul_b;
	logic signed [PW-1:0] prod;
	iter_ctl_t            root_ctl, div_ctl;
	iter_sts_t            root_sts, div_sts;
	logic [ROOT_W-1:0]    root;
	logic [RAD_W-1:0]     radicand;
	logic signed [STEP_W-1:0] div_num, quo;

	dar_mul #(.AW(AW), .BW(BW)) u_mul (
		.clk(clk), .en(mul_en), .a(mul_a), .b(mul_b), .p_q(prod)
	);

	dar_root u_root (
		.clk(clk), .arst_n(arst_n), .ctl(root_ctl), .radicand(radicand),
		.sts(root_sts), .root(root)
	);

	dar_div #(.LW(LW)) u_div (
		.clk(clk), .arst_n(arst_n), .ctl(div_ctl), .num(div_num), .den(eff_len),
		.sts(div_sts), .quo(quo)
	);

	// Datapath helpers.
	logic                  accept, can_write, last;
	logic signed [SW-1:0]  xs;
	logic [DIST_W-1:0]     zmag, src_dist, dv;
	logic [DIST_W+4:0]     dv24;
	logic [GAIN_W-1:0]     ratio_d, gmax, gdelta;
	logic signed [GAIN_W+1:0] gsum, csum;
	logic signed [OW-1:0]  scaled;
	logic signed [SAMPLE_BITS-1:0] result;

	assign accept    = in_valid && !in_stall;
	assign can_write = !out_valid_q || !out_stall;
	assign xs        = {sample_q, 8'b0};
	assign last      = ({1'b0, idx_q} + {{LW{1'b0}}, 1'b1}) >= {1'b0, eff_len};

	// Distance and attenuation ratio.
	assign zmag = DIST_W'(-{pos_z_q[POS_W-1], pos_z_q});
	always_comb begin
		if (!pos_z_q[POS_W-1])
			src_dist = DIST_W'(root);
		else if (root < ONE_Q12[ROOT_W-1:0])
			src_dist = ONE_Q12 + zmag;
		else
			src_dist = DIST_W'(root) + zmag;
		dv   = src_dist - ONE_Q12;
		dv24 = {dv, 4'b0} + {1'b0, dv, 3'b0};
		if (src_dist <= ONE_Q12)
			ratio_d = '0;
		else if (dv24 > (DIST_W+5)'(UNITY_Q16))
			ratio_d = UNITY_Q16;
		else
			ratio_d = dv24[GAIN_W-1:0];
	end

	assign gmax   = (gain_max_q > UNITY_Q16) ? UNITY_Q16 : gain_max_q;
	assign gdelta = UNITY_Q16 - gmax;
	assign radicand = pos_z_q[POS_W-1] ? acc_q : acc_q + prod[RAD_W-1:0];

	// Ramp updates with saturation.
	assign gsum = $signed({2'b00, cur_gain_q}) + (GAIN_W+2)'(gain_step_q);
	assign csum = $signed({3'b000, cur_coef_q}) + (GAIN_W+2)'(coef_step_q);

	// Output scaling and saturation.
	assign scaled = prod[PW-1:24];
	always_comb begin
		if (scaled > OW'($signed({1'b0, {(SAMPLE_BITS-1){1'b1}}})))
			result = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
		else if (scaled < OW'($signed({1'b1, {(SAMPLE_BITS-1){1'b0}}})))
			result = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
		else
			result = scaled[SAMPLE_BITS-1:0];
	end

	// Next-state logic.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:      if (accept) state_d = (idx_q == '0) ? ST_MX : ST_UPD;
			ST_MX:        state_d = ST_MY;
			ST_MY:        state_d = ST_MZ;
			ST_MZ:        state_d = ST_ROOT_GO;
			ST_ROOT_GO:   state_d = ST_ROOT_WAIT;
			ST_ROOT_WAIT: if (root_sts.done) state_d = ST_RATIO;
			ST_RATIO:     state_d = ST_MUL_G;
			ST_MUL_G:     state_d = ST_MUL_C;
			ST_MUL_C:     state_d = ST_DIVG_GO;
			ST_DIVG_GO:   state_d = ST_DIVG_WAIT;
			ST_DIVG_WAIT: if (div_sts.done) state_d = ST_DIVC_GO;
			ST_DIVC_GO:   state_d = ST_DIVC_WAIT;
			ST_DIVC_WAIT: if (div_sts.done) state_d = ST_UPD;
			ST_UPD:       state_d = bypass_q ? ST_OUT : ST_F1;
			ST_F1:        state_d = ST_F1W;
			ST_F1W:       state_d = ST_F2;
			ST_F2:        state_d = ST_F2W;
			ST_F2W:       state_d = ST_G;
			ST_G:         state_d = ST_OUT;
			ST_OUT:       if (can_write) state_d = ST_IDLE;
			default:      state_d = ST_IDLE;
		endcase
	end

	// Output logic: unit controls and multiplier operands.
	always_comb begin
		in_stall       = 1'b1;
		mul_en         = 1'b0;
		mul_a          = '0;
		mul_b          = '0;
		root_ctl.start = 1'b0;
		div_ctl.start  = 1'b0;
		div_num        = '0;
		unique case (state_q)
			ST_IDLE: in_stall = 1'b0;
			ST_MX: begin
				mul_en = 1'b1;
				mul_a  = AW'(pos_x_q);
				mul_b  = BW'(pos_x_q);
			end
			ST_MY: begin
				mul_en = 1'b1;
				mul_a  = AW'(pos_y_q);
				mul_b  = BW'(pos_y_q);
			end
			ST_MZ: begin
				mul_en = 1'b1;
				mul_a  = AW'(pos_z_q);
				mul_b  = BW'(pos_z_q);
			end
			ST_ROOT_GO: root_ctl.start = 1'b1;
			ST_MUL_G: begin
				mul_en = 1'b1;
				mul_a  = AW'(ratio_q);
				mul_b  = BW'(gdelta);
			end
			ST_MUL_C: begin
				mul_en = 1'b1;
				mul_a  = AW'(ratio_q);
				mul_b  = BW'(coef_max_q);
			end
			ST_DIVG_GO: begin
				div_ctl.start = 1'b1;
				div_num = $signed({1'b0, tgain_q}) - $signed({1'b0, cur_gain_q});
			end
			ST_DIVC_GO: begin
				div_ctl.start = 1'b1;
				div_num = $signed({2'b00, tcoef_q}) - $signed({2'b00, cur_coef_q});
			end
			ST_F1: begin
				mul_en = 1'b1;
				mul_a  = AW'(stage_one_q) - AW'(xs);
				mul_b  = BW'(cur_coef_q);
			end
			ST_F2: begin
				mul_en = 1'b1;
				mul_a  = AW'(stage_two_q) - AW'(stage_one_q);
				mul_b  = BW'(cur_coef_q);
			end
			ST_G: begin
				mul_en = 1'b1;
				mul_a  = AW'(stage_two_q);
				mul_b  = BW'(cur_gain_q);
			end
			default: ;
		endcase
	end

	// Sequencer and ramp state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cur_gain_q  <= UNITY_Q16;
			cur_coef_q  <= '0;
			gain_step_q <= '0;
			coef_step_q <= '0;
			stage_one_q <= '0;
			stage_two_q <= '0;
			idx_q       <= '0;
			bypass_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			// A new result is posted or the held one is taken.
			if (state_q == ST_OUT && can_write)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_MX: bypass_q <= 1'b0;
				ST_DIVG_WAIT: if (div_sts.done) gain_step_q <= quo;
				ST_DIVC_WAIT: if (div_sts.done) begin
					coef_step_q <= quo;
					bypass_q    <= (quo == '0) && (gain_step_q == '0) && (ratio_q == '0);
				end
				ST_UPD: if (!bypass_q) begin
					if (gsum < 0)
						cur_gain_q <= '0;
					else if (gsum > $signed({2'b00, UNITY_Q16}))
						cur_gain_q <= UNITY_Q16;
					else
						cur_gain_q <= gsum[GAIN_W-1:0];
					if (csum < 0)
						cur_coef_q <= '0;
					else if (csum > $signed({3'b000, COEF_MAX}))
						cur_coef_q <= COEF_MAX;
					else
						cur_coef_q <= csum[COEF_W-1:0];
				end
				ST_F1W: stage_one_q <= xs + prod[SW+15:16];
				ST_F2W: stage_two_q <= stage_one_q + prod[SW+15:16];
				ST_OUT: if (can_write) begin
					idx_q <= last ? '0 : idx_q + LW'(1);
				end
				default: ;
			endcase
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (accept)
			sample_q <= sample_in;
		case (state_q)
			ST_MY:    acc_q <= prod[RAD_W-1:0];
			ST_MZ:    acc_q <= acc_q + prod[RAD_W-1:0];
			ST_RATIO: ratio_q <= ratio_d;
			ST_MUL_C: tgain_q <= UNITY_Q16 - prod[GAIN_W+15:16];
			ST_DIVG_GO: tcoef_q <= prod[COEF_W+15:16];
			ST_OUT: if (can_write) begin
				sample_out_q <= bypass_q ? sample_q : result;
				block_end_q  <= last;
			end
			default: ;
		endcase
	end

	assign out_valid  = out_valid_q;
	assign sample_out = sample_out_q;
	assign block_end  = block_end_q;

	// Checks on the block's own logic.
	a_gain_range: assert property (@(posedge clk) disable iff (!arst_n)
		cur_gain_q <= UNITY_Q16)
		else $error("ramp gain above unity");

	a_bypass_steps: assert property (@(posedge clk) disable iff (!arst_n)
		bypass_q |-> (gain_step_q == '0) && (coef_step_q == '0))
		else $error("bypass with nonzero ramp step");

	a_div_owner: assert property (@(posedge clk) disable iff (!arst_n)
		div_sts.busy |-> (state_q == ST_DIVG_WAIT || state_q == ST_DIVC_WAIT))
		else $error("divider busy outside a division state");

	a_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_OUT && can_write) |=> state_q == ST_IDLE && out_valid_q)
		else $error("result write did not complete the item");

endmodule

// ===== rtl/dar_mul.sv =====
// Shared registered signed multiplier.
`timescale 1ns / 1ps
module dar_mul #(
	parameter int AW = 25,
	parameter int BW = 18
) (
	input  logic                 clk,
	input  logic                 en,
	input  logic signed [AW-1:0] a,
	input  logic signed [BW-1:0] b,
	output logic signed [AW+BW-1:0] p_q
);

	// Product is registered and held while not enabled.
	always_ff @(posedge clk) begin
		if (en) begin
			p_q <= a * b;
		end
	end

endmodule

// ===== rtl/dar_root.sv =====
// Iterative integer square root, two radicand bits per cycle.
`timescale 1ns / 1ps
module dar_root (
	input  logic                        clk,
	input  logic                        arst_n,
	input  dar_pkg::iter_ctl_t          ctl,
	input  logic [dar_pkg::RAD_W-1:0]   radicand,
	output dar_pkg::iter_sts_t          sts,
	output logic [dar_pkg::ROOT_W-1:0]  root
);
	import dar_pkg::*;

	logic [RAD_W-1:0]  rad_q;
	logic [ROOT_W+1:0] rem_q;
	logic [ROOT_W-1:0] root_q;
	logic [3:0]        cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [ROOT_W+3:0] rem_sh;
	logic [ROOT_W+3:0] trial;
	logic [ROOT_W+3:0] diff;
	logic              ge;

	// One digit of the root per cycle.
	assign rem_sh = {rem_q, rad_q[RAD_W-1 -: 2]};
	assign trial  = {2'b00, root_q, 2'b01};
	assign ge     = rem_sh >= trial;
	assign diff   = rem_sh - trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 4'd1;
				if (cnt_q == 4'd15) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			rad_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q  <= {rad_q[RAD_W-3:0], 2'b00};
			rem_q  <= ge ? diff[ROOT_W+1:0] : rem_sh[ROOT_W+1:0];
			root_q <= {root_q[ROOT_W-2:0], ge};
		end
	end

	assign sts.busy = busy_q;
	assign sts.done = done_q;
	assign root     = root_q;

endmodule

// ===== rtl/dar_div.sv =====
// Iterative signed divider by an unsigned length, truncating toward zero.
`timescale 1ns / 1ps
module dar_div #(
	parameter int LW = 13
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  dar_pkg::iter_ctl_t                ctl,
	input  logic signed [dar_pkg::STEP_W-1:0] num,
	input  logic [LW-1:0]                     den,
	output dar_pkg::iter_sts_t                sts,
	output logic signed [dar_pkg::STEP_W-1:0] quo
);
	import dar_pkg::*;

	localparam int MW = STEP_W - 1;

	logic [MW-1:0]     quo_q;
	logic [LW:0]       rem_q;
	logic              neg_q;
	logic [4:0]        cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [STEP_W-1:0] mag;
	logic [LW:0]       rem_sh;
	logic              ge;

	assign mag    = num[STEP_W-1] ? -num : num;
	assign rem_sh = {rem_q[LW-1:0], quo_q[MW-1]};
	assign ge     = rem_sh >= {1'b0, den};

	// One quotient bit per cycle, restoring.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'(MW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			quo_q <= mag[MW-1:0];
			neg_q <= num[STEP_W-1];
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? rem_sh - {1'b0, den} : rem_sh;
			quo_q <= {quo_q[MW-2:0], ge};
		end
	end

	assign sts.busy = busy_q;
	assign sts.done = done_q;
	assign quo      = neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the distance attenuation ramped low-pass core.
`timescale 1ns / 1ps
module tb;
	import dar_pkg::*;

	// Register indexes the block does not decode.
	localparam logic [IDX_W-1:0] CFG_SPARE_LO = 3'd6;
	localparam logic [IDX_W-1:0] CFG_SPARE_HI = 3'd7;

	typedef enum logic {ROW_CFG, ROW_SMP} row_kind_t;

	typedef struct {
		row_kind_t                 kind;
		logic [IDX_W-1:0]          idx;
		logic [CFG_W-1:0]          data;
		logic signed [15:0]        smp;
		bit                        typed;
		logic signed [15:0]        want_smp;
		bit                        want_end;
	} stim_row_t;

	typedef struct {
		logic signed [15:0] smp;
		bit                 last;
	} audio_res_t;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     cfg_we = 1'b0;
	logic [IDX_W-1:0]         cfg_index = '0;
	logic [CFG_W-1:0]         cfg_data = '0;
	logic                     in_valid = 1'b0;
	logic                     in_stall;
	logic signed [15:0]       sample_in = '0;
	logic                     out_valid;
	logic                     out_stall = 1'b0;
	logic signed [15:0]       sample_out;
	logic                     block_end;

	distance_attenuation_ramped_lowpass_core i_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall), .sample_in(sample_in),
		.out_valid(out_valid), .out_stall(out_stall),
		.sample_out(sample_out), .block_end(block_end)
	);

	always #4 clk = ~clk;

	// Shadow of the configuration and the ramp and filter state.
	logic [15:0] sh_x = 16'd0, sh_y = 16'd0, sh_z = 16'd0;
	logic [16:0] sh_gmax = 17'd65536;
	logic [15:0] sh_cmax = 16'd0;
	logic [12:0] sh_blen = 13'd256;
	longint gain_now = 65536, coef_now = 0, gain_inc = 0, coef_inc = 0;
	longint stage_a = 0, stage_b = 0;
	int     pos_in_block = 0;
	bit     pass_through = 1'b0;

	audio_res_t pending[$];
	int         mismatches = 0;
	int         send_idle_pct = 33;
	int         recv_idle_pct = 83;

	function automatic longint clip(longint v, longint lo, longint hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	// Floor square root, two bits per iteration.
	function automatic longint unsigned floor_root(longint unsigned v);
		longint unsigned acc, b;
		acc = 0;
		b = 64'd1 << 62;
		while (b > v)
			b >>= 2;
		while (b != 0) begin
			if (v >= acc + b) begin
				v -= acc + b;
				acc = (acc >> 1) + b;
			end else begin
				acc >>= 1;
			end
			b >>= 2;
		end
		return acc;
	endfunction

	function automatic longint ramp_len();
		return sh_blen == 0 ? 1 : (sh_blen > 4096 ? 4096 : longint'(sh_blen));
	endfunction

	// Distance, attenuation ratio and ramp steps at the start of a block.
	task automatic start_block();
		longint px, py, pz, rad, src_dist, ratio, gm, tg, tc;
		longint unsigned r2;
		px = longint'($signed(sh_x));
		py = longint'($signed(sh_y));
		pz = longint'($signed(sh_z));
		r2 = px * px + py * py;
		rad = floor_root(r2);
		if (pz < 0 && rad < 4096)
			src_dist = 4096 - pz;
		else if (pz < 0)
			src_dist = rad - pz;
		else
			src_dist = floor_root(r2 + pz * pz);
		ratio = src_dist <= 4096 ? 0 : clip((src_dist - 4096) * 24, 0, 65536);
		gm = clip(longint'(sh_gmax), 0, 65536);
		tg = 65536 - ((ratio * (65536 - gm)) >>> 16);
		tc = (ratio * longint'(sh_cmax)) >>> 16;
		gain_inc = (tg - gain_now) / ramp_len();
		coef_inc = (tc - coef_now) / ramp_len();
		pass_through = gain_inc == 0 && coef_inc == 0 && ratio == 0;
	endtask

	task automatic attenuate(input logic signed [15:0] s, output audio_res_t r);
		longint xv, xs, y;
		bit fin;
		xv = longint'(s);
		if (pos_in_block == 0)
			start_block();
		if (pass_through) begin
			y = xv;
		end else begin
			xs = xv * 256;
			coef_now = clip(coef_now + coef_inc, 0, 65535);
			gain_now = clip(gain_now + gain_inc, 0, 65536);
			stage_a = xs + (((stage_a - xs) * coef_now) >>> 16);
			stage_b = stage_a + (((stage_b - stage_a) * coef_now) >>> 16);
			y = clip((stage_b * gain_now) >>> 24, -32768, 32767);
		end
		fin = pos_in_block + 1 >= ramp_len();
		pos_in_block = fin ? 0 : pos_in_block + 1;
		r.smp = y[15:0];
		r.last = fin;
	endtask

	// Drop valid and wait until every result has come back.
	task automatic drain();
		if (in_valid)
			in_valid <= 1'b0;
		@(posedge clk);
		while (pending.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	// One register write, with the enable dropped afterwards.
	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] v);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_POS_X:     sh_x = v[15:0];
			CFG_POS_Y:     sh_y = v[15:0];
			CFG_POS_Z:     sh_z = v[15:0];
			CFG_GAIN_MAX:  sh_gmax = v[16:0];
			CFG_COEF_MAX:  sh_cmax = v[15:0];
			CFG_BLOCK_LEN: sh_blen = v[12:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	// Offer one item, with a random gap first, and wait until it is taken.
	task automatic push_sample(input logic signed [15:0] s, input bit typed,
			input audio_res_t want);
		int gap;
		audio_res_t r;
		gap = ($urandom_range(0, 99) < send_idle_pct) ? $urandom_range(1, 6) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		sample_in <= s;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		attenuate(s, r);
		if (typed)
			r = want;
		pending = {pending, r};
	endtask

	function automatic logic signed [15:0] rand_sample();
		case ($urandom_range(0, 5))
			0: return 16'sh7FFF;
			1: return 16'sh8000;
			2: return 16'($urandom_range(0, 255)) - 16'sd128;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [15:0] rand_coord();
		case ($urandom_range(0, 3))
			0: return 16'($urandom_range(0, 12000)) - 16'd6000;
			1: return 16'($urandom_range(0, 4096));
			default: return 16'($urandom);
		endcase
	endfunction

	// Result checker and receiver stall.
	always @(posedge clk) begin
		audio_res_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result sample_out=%0d block_end=%0b",
						sample_out, block_end);
			end else begin
				e = pending.pop_front();
				if (sample_out !== e.smp || block_end !== e.last) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: sample_out exp %0d got %0d, block_end exp %0b got %0b",
							e.smp, sample_out, e.last, block_end);
				end
			end
		end
		out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
	end

	stim_row_t plan[$];

	task automatic add_row(input stim_row_t r);
		plan = {plan, r};
	endtask

	function automatic stim_row_t cfg_row(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] v);
		stim_row_t r;
		r = '{ROW_CFG, idx, v, 16'sd0, 1'b0, 16'sd0, 1'b0};
		return r;
	endfunction

	function automatic stim_row_t smp_row(logic signed [15:0] s, bit typed,
			logic signed [15:0] ws, bit we);
		stim_row_t r;
		r = '{ROW_SMP, CFG_POS_X, '0, s, typed, ws, we};
		return r;
	endfunction

	// Stimulus: directed table, then random phases under three idling mixes.
	initial begin
		audio_res_t w;
		int n;
		// Reset state: the source sits at the origin, so samples pass unchanged.
		add_row(smp_row(16'sh7FFF, 1, 16'sh7FFF, 0));
		add_row(smp_row(16'sh8000, 1, 16'sh8000, 0));
		add_row(smp_row(16'sd0, 1, 16'sd0, 0));
		add_row(smp_row(16'sd1, 1, 16'sd1, 0));
		add_row(cfg_row(CFG_BLOCK_LEN, 17'd1));
		add_row(smp_row(-16'sd1, 1, -16'sd1, 1));
		// Below the floor with a small radius: attenuation ratio of three quarters, zero gain limit.
		add_row(cfg_row(CFG_POS_Z, 17'h0F800));
		add_row(cfg_row(CFG_GAIN_MAX, 17'd0));
		add_row(cfg_row(CFG_COEF_MAX, 17'hFFFF));
		add_row(cfg_row(CFG_BLOCK_LEN, 17'd2));
		add_row(smp_row(16'sh7FFF, 0, 0, 0));
		add_row(smp_row(16'sh7FFF, 0, 0, 0));
		add_row(smp_row(16'sh8000, 0, 0, 0));
		// Below the floor far out, gain above unity.
		add_row(cfg_row(CFG_POS_X, 17'h07FFF));
		add_row(cfg_row(CFG_POS_Y, 17'h08000));
		add_row(cfg_row(CFG_POS_Z, 17'h0FFFF));
		add_row(cfg_row(CFG_GAIN_MAX, 17'h1FFFF));
		add_row(smp_row(16'sd1000, 0, 0, 0));
		add_row(smp_row(-16'sd1000, 0, 0, 0));
		// Above the floor, zero block length, then the largest length the register holds.
		add_row(cfg_row(CFG_POS_Z, 17'h07FFF));
		add_row(cfg_row(CFG_BLOCK_LEN, 17'd0));
		add_row(smp_row(16'sh7FFF, 0, 0, 0));
		add_row(smp_row(16'sh8000, 0, 0, 0));
		add_row(cfg_row(CFG_BLOCK_LEN, 17'h1FFF));
		add_row(cfg_row(CFG_SPARE_HI, 17'h1FFFF));
		add_row(cfg_row(CFG_SPARE_LO, 17'h00000));
		add_row(smp_row(16'sh1234, 0, 0, 0));
		// Back to the origin: the ramp returns toward unity and no filtering.
		add_row(cfg_row(CFG_POS_X, 17'd0));
		add_row(cfg_row(CFG_POS_Y, 17'd0));
		add_row(cfg_row(CFG_POS_Z, 17'd0));
		add_row(cfg_row(CFG_BLOCK_LEN, 17'd3));
		for (int k = 0; k < 6; k++)
			add_row(smp_row(16'sh4000 - 16'(k * 9000), 0, 0, 0));

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[k]) begin
			if (plan[k].kind == ROW_CFG) begin
				if (k == 0 || plan[k-1].kind != ROW_CFG)
					drain();
				write_reg(plan[k].idx, plan[k].data);
			end else begin
				w.smp = plan[k].want_smp;
				w.last = plan[k].want_end;
				push_sample(plan[k].smp, plan[k].typed, w);
			end
		end

		for (int m = 0; m < 3; m++) begin
			send_idle_pct = (m == 0) ? 33 : (m == 1 ? 83 : 0);
			recv_idle_pct = (m == 0) ? 83 : (m == 1 ? 33 : 0);
			n = 0;
			while (n < 370) begin
				drain();
				write_reg(CFG_POS_X, 17'(rand_coord()));
				write_reg(CFG_POS_Y, 17'(rand_coord()));
				write_reg(CFG_POS_Z, 17'(rand_coord()));
				write_reg(CFG_GAIN_MAX, ($urandom_range(0, 3) == 0) ?
					17'($urandom) : 17'($urandom_range(0, 65536)));
				write_reg(CFG_COEF_MAX, 17'($urandom_range(0, 65535)));
				case ($urandom_range(0, 9))
					0: write_reg(CFG_BLOCK_LEN, 17'd0);
					1: write_reg(CFG_BLOCK_LEN, 17'($urandom_range(4096, 8191)));
					default: write_reg(CFG_BLOCK_LEN, 17'($urandom_range(1, 12)));
				endcase
				repeat ($urandom_range(5, 30)) begin
					push_sample(rand_sample(), 0, w);
					n++;
				end
			end
		end

		drain();
		repeat (100) @(posedge clk);
		if (mismatches == 0 && pending.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	// Run limit.
	initial begin
		#20ms;
		$display("status: fail");
		$finish;
	end

endmodule
